>>> rtl/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// pcsc_pkg
// Shared widths, codes and types of the parity check syndrome corrector.
// ----------------------------------------------------------------------------
package pcsc_pkg;

  localparam int WORD_W   = 9;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int CHAR_W   = 7;

  localparam int NUM_REGS = 4;
  localparam int REG_W    = 9;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int CODE_BITS_DEF  = 9;
  localparam int CHECK_ROWS_DEF = 4;
  localparam int DATA_BITS_DEF  = 5;

  localparam logic [STATUS_W-1:0] ST_CLEAN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FIXED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCORR  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BASE  = 7'd64;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;

  typedef struct packed {
    logic [NUM_REGS-1:0][REG_W-1:0] row;
  } check_matrix_t;

endpackage

>>> rtl/pcsc_if.sv
// ----------------------------------------------------------------------------
// pcsc_in_if / pcsc_out_if
// Valid/ready channels for received codewords and decoded results.
// ----------------------------------------------------------------------------
interface pcsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcsc_pkg::WORD_W-1:0] received_word;

  modport source (output valid, output received_word, input ready);
  modport sink   (input valid, input received_word, output ready);
  modport monitor (input valid, input received_word, input ready);
endinterface

interface pcsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcsc_pkg::WORD_W-1:0]   corrected_word;
  logic [pcsc_pkg::STATUS_W-1:0] error_status;
  logic [pcsc_pkg::POS_W-1:0]    flipped_position;
  logic [pcsc_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output corrected_word, output error_status,
                  output flipped_position, output char_code, input ready);
  modport sink   (input valid, input corrected_word, input error_status,
                  input flipped_position, input char_code, output ready);
  modport monitor (input valid, input corrected_word, input error_status,
                   input flipped_position, input char_code, input ready);
endinterface

>>> rtl/pcsc_regs.sv
// ----------------------------------------------------------------------------
// pcsc_regs
// APB register file holding the rows of the parity-check matrix.
// ----------------------------------------------------------------------------
module pcsc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcsc_pkg::ADDR_W-1:0] paddr,
  input  logic [pcsc_pkg::DATA_W-1:0] pwdata,
  output logic [pcsc_pkg::DATA_W-1:0] prdata,
  output pcsc_pkg::check_matrix_t     matrix
);

  localparam int IDX_W = $clog2(pcsc_pkg::NUM_REGS);

  logic [IDX_W-1:0] idx;

  assign idx = paddr[pcsc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= '0;
    end else if (psel && penable && pwrite) begin
      matrix.row[idx] <= pwdata[pcsc_pkg::REG_W-1:0];
    end
  end

  assign prdata = {{(pcsc_pkg::DATA_W-pcsc_pkg::REG_W){1'b0}}, matrix.row[idx]};

endmodule

>>> rtl/parity_check_syndrome_corrector.sv
// ----------------------------------------------------------------------------
// parity_check_syndrome_corrector
// Single-error syndrome decoder over a programmable 4x9 parity-check matrix,
// with character extraction from the leading data bits.
//
//   channel    kind        payload
//   received   sink        received_word
//   decoded    source      corrected_word, error_status, flipped_position,
//                          char_code
//   apb        slave       check_row_0..3 at 0x0, 0x4, 0x8, 0xC
//
// Four-stage pipeline: capture, syndrome, column match, correct/encode.
// One word per cycle while decoded is not stalled; each stage registers its result.
// Synchronous reset clears the valid bits and the matrix rows.
// A stall on decoded holds each stage that has a word behind it.
// ----------------------------------------------------------------------------
module parity_check_syndrome_corrector #(
  parameter int CODE_BITS  = pcsc_pkg::CODE_BITS_DEF,
  parameter int CHECK_ROWS = pcsc_pkg::CHECK_ROWS_DEF,
  parameter int DATA_BITS  = pcsc_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  pcsc_in_if.sink                     received,
  pcsc_out_if.source                  decoded,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcsc_pkg::ADDR_W-1:0] paddr,
  input  logic [pcsc_pkg::DATA_W-1:0] pwdata,
  output logic [pcsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int WORD_W   = pcsc_pkg::WORD_W;
  localparam int EFF_BITS = (CODE_BITS < WORD_W) ? CODE_BITS : WORD_W;
  localparam int EFF_ROWS = (CHECK_ROWS < pcsc_pkg::NUM_REGS) ? CHECK_ROWS
                                                               : pcsc_pkg::NUM_REGS;
  localparam int SUM_W    = pcsc_pkg::CHAR_W + DATA_BITS;

  pcsc_pkg::check_matrix_t matrix;

  pcsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .matrix  (matrix)
  );

  assign pready = 1'b1;

  // stage valids and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || decoded.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign received.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= received.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: capture, drop bits above the code length
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] w1;

  always_comb begin
    mask = '0;
    for (int c = 0; c < EFF_BITS; c++) begin
      mask[c] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) w1 <= received.received_word & mask;
  end

  // stage 2: syndrome
  logic [EFF_ROWS-1:0] syn_next, syn2;
  logic [WORD_W-1:0]   w2;

  always_comb begin
    for (int r = 0; r < EFF_ROWS; r++) begin
      syn_next[r] = ^(matrix.row[r] & w1);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      w2   <= w1;
      syn2 <= syn_next;
    end
  end

  // stage 3: compare syndrome with every column
  logic [EFF_BITS-1:0] match_next, match3;
  logic                err3;
  logic [WORD_W-1:0]   w3;

  always_comb begin
    logic [EFF_ROWS-1:0] col;
    for (int c = 0; c < EFF_BITS; c++) begin
      for (int r = 0; r < EFF_ROWS; r++) begin
        col[r] = matrix.row[r][c];
      end
      match_next[c] = (col == syn2) && (syn2 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      w3     <= w2;
      match3 <= match_next;
      err3   <= (syn2 != '0);
    end
  end

  // stage 4: lowest match wins, flip, extract character
  logic [EFF_BITS-1:0]           first;
  logic [WORD_W-1:0]             flip;
  logic [WORD_W-1:0]             wf;
  logic [pcsc_pkg::POS_W-1:0]    pos;
  logic [pcsc_pkg::STATUS_W-1:0] status;
  logic [DATA_BITS-1:0]          v;
  logic [SUM_W-1:0]              vsum;
  logic [pcsc_pkg::CHAR_W-1:0]   ch;

  always_comb begin
    first = match3 & (~match3 + 1'b1);
    flip  = '0;
    pos   = '0;
    for (int c = 0; c < EFF_BITS; c++) begin
      flip[c] = first[c];
      if (first[c]) pos = pos | pcsc_pkg::POS_W'(c);
    end
    wf = w3 ^ flip;
    if (!err3) begin
      status = pcsc_pkg::ST_CLEAN;
    end else if (match3 != '0) begin
      status = pcsc_pkg::ST_FIXED;
    end else begin
      status = pcsc_pkg::ST_UNCORR;
    end
    for (int j = 0; j < DATA_BITS; j++) begin
      v[DATA_BITS-1-j] = wf[j];
    end
    vsum = SUM_W'(v) + SUM_W'(pcsc_pkg::CHAR_BASE);
    ch   = (v == '0) ? pcsc_pkg::CHAR_SPACE : vsum[pcsc_pkg::CHAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      decoded.corrected_word   <= wf;
      decoded.error_status     <= status;
      decoded.flipped_position <= pos;
      decoded.char_code        <= ch;
    end
  end

  assign decoded.valid = v4;

endmodule

>>> rtl/pcsc_checker.sv
// ----------------------------------------------------------------------------
// pcsc_checker
// Port-level checks of the syndrome corrector, bound to the top level.
// ----------------------------------------------------------------------------
module pcsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          received_valid,
  input logic                          received_ready,
  input logic                          decoded_valid,
  input logic                          decoded_ready,
  input logic [pcsc_pkg::WORD_W-1:0]   corrected_word,
  input logic [pcsc_pkg::STATUS_W-1:0] error_status,
  input logic [pcsc_pkg::POS_W-1:0]    flipped_position,
  input logic [pcsc_pkg::CHAR_W-1:0]   char_code
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !decoded_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && !decoded_ready |=> decoded_valid &&
      $stable(corrected_word) && $stable(error_status) &&
      $stable(flipped_position) && $stable(char_code))
    else $error("stalled result changed");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    decoded_ready |-> received_ready)
    else $error("input stalled while output drains");

  a_pos_only_fixed: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && error_status != pcsc_pkg::ST_FIXED |->
      flipped_position == '0)
    else $error("flip position without a correction");

endmodule

bind parity_check_syndrome_corrector pcsc_checker u_pcsc_checker (
  .clk              (clk),
  .rst              (rst),
  .received_valid   (received.valid),
  .received_ready   (received.ready),
  .decoded_valid    (decoded.valid),
  .decoded_ready    (decoded.ready),
  .corrected_word   (decoded.corrected_word),
  .error_status     (decoded.error_status),
  .flipped_position (decoded.flipped_position),
  .char_code        (decoded.char_code)
);
